// File: rtl/altitude_filter_velocity_estimator_assert.svh
// Assertion macros for the altitude filter checker
`ifndef ALTITUDE_FILTER_VELOCITY_ESTIMATOR_ASSERT_SVH
`define ALTITUDE_FILTER_VELOCITY_ESTIMATOR_ASSERT_SVH

// Clocked assertion, masked while reset is asserted
`define AFVE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("altitude filter assertion failed");

// Clocked assertion that also holds across reset
`define AFVE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("altitude filter reset assertion failed");

`endif

// File: rtl/afve_pkg.sv
// Shared widths, register indexes, reset values and types for the altitude filter
`timescale 1ns / 1ps

package afve_pkg;

    localparam int ALT_W      = 24;
    localparam int TIME_W     = 32;
    localparam int INTV_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int EPS_W      = 16;
    localparam int DELTA_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier: signed 25 x signed 18
    localparam int MUL_A_W    = ALT_W + 1;
    localparam int MUL_B_W    = WEIGHT_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_BIAS = 32768;

    // speed numerator |delta * 1000| < 2^(ALT_W + 10)
    localparam int SPEED_SCALE = 1000;
    localparam int NUM_W       = ALT_W + 10;
    localparam int DIV_CNT_W   = $clog2(NUM_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_WEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_EPS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_REF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_DELTA = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_VEL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_VEL  = 3'd7;

    // register reset values
    localparam logic [WEIGHT_W-1:0] RST_PREV_WEIGHT  = 17'd52429;
    localparam logic [WEIGHT_W-1:0] RST_RAW_WEIGHT   = 17'd13107;
    localparam logic [EPS_W-1:0]    RST_ZERO_EPS     = 16'd26;
    localparam logic [INTV_W-1:0]   RST_MIN_INTERVAL = 16'd1;
    localparam logic [ALT_W-1:0]    RST_LAUNCH_REF   = 24'd0;
    localparam logic [DELTA_W-1:0]  RST_LAUNCH_DELTA = 23'd2560;
    localparam logic [ALT_W-1:0]    RST_DESCENT_VEL  = 24'hFFFF00;
    localparam logic [DELTA_W-1:0]  RST_LANDING_VEL  = 23'd128;

    typedef logic signed [ALT_W-1:0] t_alt;
    typedef logic [INTV_W-1:0]       t_interval;
    typedef logic [TIME_W-1:0]       t_time;

endpackage

// File: rtl/afve_if.sv
// Valid/ready channel interfaces for altitude samples and filter results
`timescale 1ns / 1ps

interface afve_in_if;
    logic                 valid;
    logic                 ready;
    afve_pkg::t_alt       alt_sample;
    afve_pkg::t_interval  interval_ms;
    logic                 in_descent;

    modport source (output valid, alt_sample, interval_ms, in_descent, input ready);
    modport sink   (input valid, alt_sample, interval_ms, in_descent, output ready);
endinterface

interface afve_out_if;
    logic                 valid;
    logic                 ready;
    afve_pkg::t_alt       smoothed_altitude;
    afve_pkg::t_alt       vertical_speed;
    logic                 is_descending;
    afve_pkg::t_time      still_time_ms;

    modport source (output valid, smoothed_altitude, vertical_speed, is_descending,
                    still_time_ms, input ready);
    modport sink   (input valid, smoothed_altitude, vertical_speed, is_descending,
                    still_time_ms, output ready);
endinterface

// File: rtl/altitude_filter_velocity_estimator.sv
// Altitude smoothing filter with vertical speed, descent flag and stationary timer
`timescale 1ns / 1ps

// Each accepted altitude beat passes through the sequencer states in order before it
// reaches the result register: S_MUL_PREV and S_MUL_RAW multiply-accumulate the blend,
// S_SNAP saturates and zero-snaps it, S_MUL_DELTA forms delta * 1000, S_DIV_SETUP
// prepares a one-bit-per-cycle restoring divider in S_DIV, and S_FINISH loads the
// result. The next sample is accepted only once S_FINISH has returned to idle, so
// a new sample is never taken while one is in flight. A single 25 x 18 multiplier is
// shared by all products. The input is ready only while the sequencer is idle; a
// finished result waits in the output register while the next sample is taken,
// and the finish cycle stalls only if the previous result has not yet been taken.
// Configuration registers may be written whenever no sample is in flight.
module altitude_filter_velocity_estimator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [afve_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [afve_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    afve_in_if.sink                            i_in,
    afve_out_if.source                         o_out
);

    localparam int AW = afve_pkg::ALT_W;
    localparam int SH_W = afve_pkg::ACC_W - afve_pkg::FRAC_SHIFT;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_PREV  = 3'd1;
    localparam logic [2:0] S_MUL_RAW   = 3'd2;
    localparam logic [2:0] S_SNAP      = 3'd3;
    localparam logic [2:0] S_MUL_DELTA = 3'd4;
    localparam logic [2:0] S_DIV_SETUP = 3'd5;
    localparam logic [2:0] S_DIV       = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    localparam afve_pkg::t_alt ALT_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam afve_pkg::t_alt ALT_MIN = {1'b1, {(AW-1){1'b0}}};

    // configuration registers
    logic [afve_pkg::WEIGHT_W-1:0] r_prev_weight;
    logic [afve_pkg::WEIGHT_W-1:0] r_raw_weight;
    logic [afve_pkg::EPS_W-1:0]    r_zero_eps;
    logic [afve_pkg::INTV_W-1:0]   r_min_interval;
    afve_pkg::t_alt                r_launch_ref;
    logic [afve_pkg::DELTA_W-1:0]  r_launch_delta;
    afve_pkg::t_alt                r_descent_vel;
    logic [afve_pkg::DELTA_W-1:0]  r_landing_vel;

    // filter state
    afve_pkg::t_alt  r_filt;
    afve_pkg::t_alt  r_prev;
    afve_pkg::t_time r_still;

    // sequencer and datapath
    logic [2:0]                        r_state;
    afve_pkg::t_alt                    r_raw;
    afve_pkg::t_interval               r_interval;
    logic                              r_descent;
    logic signed [afve_pkg::ACC_W-1:0] r_acc;
    logic                              r_neg;
    logic [afve_pkg::INTV_W-1:0]       r_rem;
    logic [afve_pkg::NUM_W-1:0]        r_quo;
    afve_pkg::t_interval               r_dt;
    logic [afve_pkg::DIV_CNT_W-1:0]    r_cnt;

    // result register
    logic            r_out_valid;
    afve_pkg::t_alt  r_out_alt;
    afve_pkg::t_alt  r_out_speed;
    logic            r_out_desc;
    afve_pkg::t_time r_out_still;

    // shared multiplier
    logic signed [afve_pkg::MUL_A_W-1:0] mul_a;
    logic signed [afve_pkg::MUL_B_W-1:0] mul_b;
    logic signed [afve_pkg::PROD_W-1:0]  mul_p;
    logic signed [afve_pkg::ACC_W-1:0]   mul_ext;
    logic signed [AW:0]                  delta;

    always_comb begin
        delta = {r_filt[AW-1], r_filt} - {r_prev[AW-1], r_prev};
        case (r_state)
            S_MUL_PREV: begin
                mul_a = {r_filt[AW-1], r_filt};
                mul_b = {1'b0, r_prev_weight};
            end
            S_MUL_RAW: begin
                mul_a = {r_raw[AW-1], r_raw};
                mul_b = {1'b0, r_raw_weight};
            end
            S_MUL_DELTA: begin
                mul_a = delta;
                mul_b = afve_pkg::MUL_B_W'(afve_pkg::SPEED_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        mul_ext = {mul_p[afve_pkg::PROD_W-1], mul_p};
    end

    // blend: floor shift, saturate, zero snap
    logic signed [SH_W-1:0] blend_sh;
    afve_pkg::t_alt         blend_sat;
    logic [AW-1:0]          blend_abs;
    logic [AW-1:0]          raw_abs;
    afve_pkg::t_alt         blend_snap;

    always_comb begin
        blend_sh = r_acc[afve_pkg::ACC_W-1:afve_pkg::FRAC_SHIFT];
        if (!blend_sh[SH_W-1] && (|blend_sh[SH_W-2:AW-1])) begin
            blend_sat = ALT_MAX;
        end else if (blend_sh[SH_W-1] && !(&blend_sh[SH_W-2:AW-1])) begin
            blend_sat = ALT_MIN;
        end else begin
            blend_sat = blend_sh[AW-1:0];
        end
        blend_abs = blend_sat[AW-1] ? -blend_sat : blend_sat;
        raw_abs   = r_raw[AW-1] ? -r_raw : r_raw;
        if ((blend_abs <= AW'(r_zero_eps)) && (raw_abs <= AW'(r_zero_eps))) begin
            blend_snap = '0;
        end else begin
            blend_snap = blend_sat;
        end
    end

    // divider setup and step
    logic [afve_pkg::NUM_W-1:0]  acc_mag;
    afve_pkg::t_interval         dt_sel;
    logic [afve_pkg::INTV_W+1:0] trial;
    logic                        borrow;

    always_comb begin
        acc_mag = r_acc[afve_pkg::ACC_W-1] ? afve_pkg::NUM_W'(-r_acc)
                                           : r_acc[afve_pkg::NUM_W-1:0];
        dt_sel  = (r_interval < r_min_interval) ? r_min_interval : r_interval;
        if (dt_sel == '0) begin
            dt_sel = afve_pkg::INTV_W'(1);
        end
        trial  = {1'b0, r_rem, r_quo[afve_pkg::NUM_W-1]} - {2'b00, r_dt};
        borrow = trial[afve_pkg::INTV_W+1];
    end

    // speed saturation and flags
    afve_pkg::t_alt                 speed;
    logic [AW-1:0]                  speed_abs;
    logic signed [AW+1:0]           height;
    logic                           airborne;
    logic                           descending;
    logic [afve_pkg::TIME_W:0]      still_sum;
    afve_pkg::t_time                still_next;
    logic                           fin_load;

    always_comb begin
        if (r_neg) begin
            if ((|r_quo[afve_pkg::NUM_W-1:AW]) || (r_quo[AW-1] && (|r_quo[AW-2:0]))) begin
                speed = ALT_MIN;
            end else begin
                speed = -r_quo[AW-1:0];
            end
        end else begin
            if (|r_quo[afve_pkg::NUM_W-1:AW-1]) begin
                speed = ALT_MAX;
            end else begin
                speed = r_quo[AW-1:0];
            end
        end
        speed_abs  = speed[AW-1] ? -speed : speed;
        height     = {{2{r_filt[AW-1]}}, r_filt} - {{2{r_launch_ref[AW-1]}}, r_launch_ref};
        airborne   = height >= $signed({3'b000, r_launch_delta});
        descending = airborne && (speed <= r_descent_vel);
        still_sum  = {1'b0, r_still} + (afve_pkg::TIME_W + 1)'(r_interval);
        if (r_descent && (speed_abs <= {1'b0, r_landing_vel})) begin
            still_next = still_sum[afve_pkg::TIME_W] ? '1 : still_sum[afve_pkg::TIME_W-1:0];
        end else begin
            still_next = '0;
        end
    end

    // finish cycle loads the result register once the previous beat has left
    assign fin_load = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.smoothed_altitude = r_out_alt;
    assign o_out.vertical_speed    = r_out_speed;
    assign o_out.is_descending     = r_out_desc;
    assign o_out.still_time_ms     = r_out_still;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_weight  <= afve_pkg::RST_PREV_WEIGHT;
            r_raw_weight   <= afve_pkg::RST_RAW_WEIGHT;
            r_zero_eps     <= afve_pkg::RST_ZERO_EPS;
            r_min_interval <= afve_pkg::RST_MIN_INTERVAL;
            r_launch_ref   <= afve_pkg::RST_LAUNCH_REF;
            r_launch_delta <= afve_pkg::RST_LAUNCH_DELTA;
            r_descent_vel  <= afve_pkg::RST_DESCENT_VEL;
            r_landing_vel  <= afve_pkg::RST_LANDING_VEL;
            r_filt         <= '0;
            r_prev         <= '0;
            r_still        <= '0;
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    afve_pkg::CFG_PREV_WEIGHT:  r_prev_weight  <= i_cfg_data[afve_pkg::WEIGHT_W-1:0];
                    afve_pkg::CFG_RAW_WEIGHT:   r_raw_weight   <= i_cfg_data[afve_pkg::WEIGHT_W-1:0];
                    afve_pkg::CFG_ZERO_EPS:     r_zero_eps     <= i_cfg_data[afve_pkg::EPS_W-1:0];
                    afve_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data[afve_pkg::INTV_W-1:0];
                    afve_pkg::CFG_LAUNCH_REF:   r_launch_ref   <= i_cfg_data[AW-1:0];
                    afve_pkg::CFG_LAUNCH_DELTA: r_launch_delta <= i_cfg_data[afve_pkg::DELTA_W-1:0];
                    afve_pkg::CFG_DESCENT_VEL:  r_descent_vel  <= i_cfg_data[AW-1:0];
                    afve_pkg::CFG_LANDING_VEL:  r_landing_vel  <= i_cfg_data[afve_pkg::DELTA_W-1:0];
                    default: ;
                endcase
            end

            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_raw      <= i_in.alt_sample;
                        r_interval <= i_in.interval_ms;
                        r_descent  <= i_in.in_descent;
                        r_state    <= S_MUL_PREV;
                    end
                end
                S_MUL_PREV: begin
                    r_acc   <= mul_ext;
                    r_state <= S_MUL_RAW;
                end
                S_MUL_RAW: begin
                    r_acc   <= r_acc + mul_ext + afve_pkg::ACC_W'(afve_pkg::ROUND_BIAS);
                    r_state <= S_SNAP;
                end
                S_SNAP: begin
                    r_filt  <= blend_snap;
                    r_state <= S_MUL_DELTA;
                end
                S_MUL_DELTA: begin
                    r_acc   <= mul_ext;
                    r_state <= S_DIV_SETUP;
                end
                S_DIV_SETUP: begin
                    r_neg   <= r_acc[afve_pkg::ACC_W-1];
                    r_quo   <= acc_mag;
                    r_rem   <= '0;
                    r_dt    <= dt_sel;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!borrow) begin
                        r_rem <= trial[afve_pkg::INTV_W-1:0];
                    end else begin
                        r_rem <= {r_rem[afve_pkg::INTV_W-2:0], r_quo[afve_pkg::NUM_W-1]};
                    end
                    r_quo <= {r_quo[afve_pkg::NUM_W-2:0], !borrow};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == afve_pkg::DIV_CNT_W'(afve_pkg::NUM_W - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hold until the previous result beat has left
                    if (fin_load) begin
                        r_prev      <= r_filt;
                        r_still     <= still_next;
                        r_out_alt   <= r_filt;
                        r_out_speed <= speed;
                        r_out_desc  <= descending;
                        r_out_still <= still_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/afve_checker.sv
// Port-level checker for the altitude filter, bound to the top level
`timescale 1ns / 1ps
`include "altitude_filter_velocity_estimator_assert.svh"

module afve_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input afve_pkg::t_alt        i_out_alt,
    input afve_pkg::t_alt        i_out_speed,
    input logic                  i_out_desc,
    input afve_pkg::t_time       i_out_still
);

    logic                                         out_stall;
    logic [2*afve_pkg::ALT_W+afve_pkg::TIME_W:0]  out_beat;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_beat  = {i_out_alt, i_out_speed, i_out_desc, i_out_still};

    // a stalled result beat keeps its payload
    `AFVE_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(out_beat))

    // the sequencer is busy right after taking a sample
    `AFVE_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    // no result can come straight out of an accepted sample
    `AFVE_ASSERT(a_no_bypass, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !$rose(i_out_valid))

    // reset leaves the block idle with no pending result
    `AFVE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> i_in_ready && !i_out_valid)

endmodule

bind altitude_filter_velocity_estimator afve_checker u_afve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_alt   (o_out.smoothed_altitude),
    .i_out_speed (o_out.vertical_speed),
    .i_out_desc  (o_out.is_descending),
    .i_out_still (o_out.still_time_ms)
);

// File: sim/testbench.sv
// Self-checking testbench for the altitude filter and vertical speed estimator
`timescale 1ns / 1ps

module testbench;

    localparam int     REG_COUNT       = 1 << afve_pkg::CFG_IDX_W;
    localparam int     RAND_PHASES     = 8;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     SQUEEZE_PHASE   = 3;
    localparam int     HOLD_CYCLES     = 600;
    localparam int     TAIL_CYCLES     = 60;
    localparam int     STALL_LIMIT     = 5000;
    localparam int     DIR_ROWS        = 24;
    localparam longint ALT_HI          = (64'sd1 <<< (afve_pkg::ALT_W - 1)) - 1;
    localparam longint ALT_LO          = -ALT_HI - 1;
    localparam longint TIME_CAP        = (64'sd1 <<< afve_pkg::TIME_W) - 1;

    typedef enum {SET_RESET, SET_PASS, SET_MIN, SET_MAX, SET_RANDOM} t_reg_setting;
    typedef enum {LEG_PAD, LEG_CLIMB, LEG_APEX, LEG_FALL, LEG_LANDED} t_flight_leg;

    typedef logic [afve_pkg::CFG_DATA_W-1:0] t_reg_image [REG_COUNT];

    typedef struct packed {
        afve_pkg::t_alt  alt;
        afve_pkg::t_alt  speed;
        logic            descending;
        afve_pkg::t_time still;
    } t_sample_result;

    typedef struct {
        t_reg_setting        setting;
        afve_pkg::t_alt      raw;
        afve_pkg::t_interval intv;
        logic                descent;
        bit                  typed;
        t_sample_result      want;
    } t_directed_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [afve_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [afve_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    afve_in_if  in_ch ();
    afve_out_if out_ch ();

    altitude_filter_velocity_estimator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // register copies and filter state of the predictor
    logic [afve_pkg::WEIGHT_W-1:0]    w_prev;
    logic [afve_pkg::WEIGHT_W-1:0]    w_raw;
    logic [afve_pkg::EPS_W-1:0]       snap_eps;
    logic [afve_pkg::INTV_W-1:0]      min_dt;
    afve_pkg::t_alt                   ground_ref;
    logic [afve_pkg::DELTA_W-1:0]     lift_margin;
    afve_pkg::t_alt                   sink_rate;
    logic [afve_pkg::DELTA_W-1:0]     rest_rate;
    afve_pkg::t_alt                   est_alt;
    afve_pkg::t_alt                   last_alt;
    afve_pkg::t_time                  rest_ms;

    t_sample_result expected_results [$];

    int  samples_in;
    int  results_seen;
    int  fault_count;
    int  settings_done;
    int  phase_budget;
    bit  calm;
    bit  squeeze_req;

    // SET_PASS rows: weights 0 / 1.0 make the blend equal the raw sample
    t_directed_row dir_rows [DIR_ROWS] = '{
        '{SET_RESET, 24'sd0,        16'd10,    1'b1, 1'b1, '{24'sd0, 24'sd0, 1'b0, 32'd10}},
        '{SET_RESET, 24'sd0,        16'd65535, 1'b1, 1'b1, '{24'sd0, 24'sd0, 1'b0, 32'd65545}},
        '{SET_RESET, 24'sd20,       16'd5,     1'b0, 1'b1, '{24'sd0, 24'sd0, 1'b0, 32'd0}},
        '{SET_RESET, -24'sd26,      16'd0,     1'b1, 1'b1, '{24'sd0, 24'sd0, 1'b0, 32'd0}},
        '{SET_RESET, 24'sd100,      16'd20,    1'b0, 1'b0, '0},
        '{SET_RESET, 24'sd8388607,  16'd1,     1'b0, 1'b0, '0},
        '{SET_RESET, 24'sh800000,   16'd0,     1'b1, 1'b0, '0},
        '{SET_RESET, 24'sd25600,    16'd100,   1'b0, 1'b0, '0},
        '{SET_PASS,  24'sd0,        16'd0,     1'b0, 1'b0, '0},
        '{SET_PASS,  24'sd0,        16'd1,     1'b0, 1'b1, '{24'sd0, 24'sd0, 1'b0, 32'd0}},
        '{SET_PASS,  24'sd8388607,  16'd1,     1'b0, 1'b1,
          '{24'sd8388607, 24'sd8388607, 1'b0, 32'd0}},
        '{SET_PASS,  24'sh800000,   16'd0,     1'b0, 1'b1,
          '{24'sh800000, 24'sh800000, 1'b0, 32'd0}},
        '{SET_PASS,  24'sd25600,    16'd1000,  1'b0, 1'b1,
          '{24'sd25600, 24'sd8388607, 1'b0, 32'd0}},
        '{SET_PASS,  24'sd25344,    16'd1000,  1'b1, 1'b1,
          '{24'sd25344, -24'sd256, 1'b1, 32'd0}},
        '{SET_PASS,  24'sd25344,    16'd500,   1'b1, 1'b1,
          '{24'sd25344, 24'sd0, 1'b0, 32'd500}},
        '{SET_PASS,  24'sd25216,    16'd1000,  1'b1, 1'b1,
          '{24'sd25216, -24'sd128, 1'b0, 32'd1500}},
        '{SET_PASS,  24'sd2560,     16'd65535, 1'b1, 1'b0, '0},
        '{SET_PASS,  24'sd2559,     16'd3,     1'b1, 1'b0, '0},
        '{SET_PASS,  24'sd27,       16'd7,     1'b0, 1'b0, '0},
        '{SET_PASS,  24'sd26,       16'd7,     1'b0, 1'b0, '0},
        '{SET_MAX,   24'sd8388607,  16'd65535, 1'b1, 1'b0, '0},
        '{SET_MAX,   24'sh800000,   16'd0,     1'b1, 1'b0, '0},
        '{SET_MAX,   24'sd1000,     16'd12,    1'b0, 1'b0, '0},
        '{SET_MAX,   -24'sd1,       16'd65535, 1'b1, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat_alt(input longint v);
        return (v > ALT_HI) ? ALT_HI : ((v < ALT_LO) ? ALT_LO : v);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // one filter update: blend, zero snap, speed division, descent flag, still timer
    function automatic t_sample_result advance_filter(input afve_pkg::t_alt raw,
                                                      input afve_pkg::t_interval intv,
                                                      input logic descent);
        longint         mix;
        longint         cur;
        longint         dt;
        longint         spd;
        longint         sum;
        t_sample_result res;
        mix = longint'(est_alt) * longint'(w_prev) + longint'(raw) * longint'(w_raw)
            + 64'sd32768;
        cur = sat_alt(mix >>> afve_pkg::FRAC_SHIFT);
        if (magnitude(cur) <= longint'(snap_eps) && magnitude(longint'(raw)) <= longint'(snap_eps))
            cur = 0;
        dt = (intv < min_dt) ? longint'(min_dt) : longint'(intv);
        if (dt == 0)
            dt = 1;
        spd = sat_alt(((cur - longint'(last_alt)) * 1000) / dt);
        est_alt  = afve_pkg::t_alt'(cur);
        last_alt = afve_pkg::t_alt'(cur);
        if (descent && magnitude(spd) <= longint'(rest_rate)) begin
            sum = longint'(rest_ms) + longint'(intv);
            rest_ms = (sum > TIME_CAP) ? '1 : afve_pkg::t_time'(sum);
        end else begin
            rest_ms = '0;
        end
        res.alt        = afve_pkg::t_alt'(cur);
        res.speed      = afve_pkg::t_alt'(spd);
        res.descending = ((cur - longint'(ground_ref)) >= longint'(lift_margin))
                      && (spd <= longint'(sink_rate));
        res.still      = rest_ms;
        return res;
    endfunction

    function automatic t_reg_image build_image(input t_reg_setting which);
        t_reg_image img;
        int         pw;
        img[afve_pkg::CFG_PREV_WEIGHT]  = afve_pkg::RST_PREV_WEIGHT;
        img[afve_pkg::CFG_RAW_WEIGHT]   = afve_pkg::RST_RAW_WEIGHT;
        img[afve_pkg::CFG_ZERO_EPS]     = afve_pkg::RST_ZERO_EPS;
        img[afve_pkg::CFG_MIN_INTERVAL] = afve_pkg::RST_MIN_INTERVAL;
        img[afve_pkg::CFG_LAUNCH_REF]   = afve_pkg::RST_LAUNCH_REF;
        img[afve_pkg::CFG_LAUNCH_DELTA] = afve_pkg::RST_LAUNCH_DELTA;
        img[afve_pkg::CFG_DESCENT_VEL]  = afve_pkg::RST_DESCENT_VEL;
        img[afve_pkg::CFG_LANDING_VEL]  = afve_pkg::RST_LANDING_VEL;
        case (which)
            SET_PASS: begin
                img[afve_pkg::CFG_PREV_WEIGHT]  = 0;
                img[afve_pkg::CFG_RAW_WEIGHT]   = 65536;
                img[afve_pkg::CFG_MIN_INTERVAL] = 0;
            end
            SET_MIN: begin
                img[afve_pkg::CFG_PREV_WEIGHT]  = 0;
                img[afve_pkg::CFG_RAW_WEIGHT]   = 0;
                img[afve_pkg::CFG_ZERO_EPS]     = 0;
                img[afve_pkg::CFG_MIN_INTERVAL] = 0;
                img[afve_pkg::CFG_LAUNCH_REF]   = 24'h800000;
                img[afve_pkg::CFG_LAUNCH_DELTA] = 0;
                img[afve_pkg::CFG_DESCENT_VEL]  = 24'h800000;
                img[afve_pkg::CFG_LANDING_VEL]  = 0;
            end
            SET_MAX: begin
                img[afve_pkg::CFG_PREV_WEIGHT]  = {afve_pkg::WEIGHT_W{1'b1}};
                img[afve_pkg::CFG_RAW_WEIGHT]   = {afve_pkg::WEIGHT_W{1'b1}};
                img[afve_pkg::CFG_ZERO_EPS]     = {afve_pkg::EPS_W{1'b1}};
                img[afve_pkg::CFG_MIN_INTERVAL] = {afve_pkg::INTV_W{1'b1}};
                img[afve_pkg::CFG_LAUNCH_REF]   = 24'h7FFFFF;
                img[afve_pkg::CFG_LAUNCH_DELTA] = {afve_pkg::DELTA_W{1'b1}};
                img[afve_pkg::CFG_DESCENT_VEL]  = 24'h7FFFFF;
                img[afve_pkg::CFG_LANDING_VEL]  = {afve_pkg::DELTA_W{1'b1}};
            end
            SET_RANDOM: begin
                // mostly weights that sum to 1.0, now and then anything the field holds
                pw = $urandom_range(0, 65536);
                img[afve_pkg::CFG_PREV_WEIGHT]  = ($urandom_range(0, 9) == 0) ?
                                                  $urandom_range(0, 131071) : pw;
                img[afve_pkg::CFG_RAW_WEIGHT]   = ($urandom_range(0, 9) == 0) ?
                                                  $urandom_range(0, 131071) : 65536 - pw;
                img[afve_pkg::CFG_ZERO_EPS]     = $urandom_range(0, 64);
                img[afve_pkg::CFG_MIN_INTERVAL] = $urandom_range(0, 40);
                img[afve_pkg::CFG_LAUNCH_REF]   =
                    afve_pkg::CFG_DATA_W'($urandom_range(0, 20000) - 10000);
                img[afve_pkg::CFG_LAUNCH_DELTA] = $urandom_range(0, 12000);
                img[afve_pkg::CFG_DESCENT_VEL]  =
                    afve_pkg::CFG_DATA_W'(-int'($urandom_range(0, 3000)));
                img[afve_pkg::CFG_LANDING_VEL]  = $urandom_range(0, 1200);
            end
            default: ;
        endcase
        return img;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic afve_pkg::t_interval pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(10, 100);
        if (r < 85) return $urandom_range(0, 9);
        if (r < 95) return $urandom_range(100, 2000);
        return $urandom_range(2000, 65535);
    endfunction

    // registers are only written with nothing in flight
    task automatic load_regs(input t_reg_setting which);
        t_reg_image                     img;
        logic [afve_pkg::CFG_IDX_W-1:0] idx;
        int                             i;
        img = build_image(which);
        for (i = 0; i < REG_COUNT; i++) begin
            idx = afve_pkg::CFG_IDX_W'(i);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= img[i];
            case (idx)
                afve_pkg::CFG_PREV_WEIGHT:  w_prev      = img[i][afve_pkg::WEIGHT_W-1:0];
                afve_pkg::CFG_RAW_WEIGHT:   w_raw       = img[i][afve_pkg::WEIGHT_W-1:0];
                afve_pkg::CFG_ZERO_EPS:     snap_eps    = img[i][afve_pkg::EPS_W-1:0];
                afve_pkg::CFG_MIN_INTERVAL: min_dt      = img[i][afve_pkg::INTV_W-1:0];
                afve_pkg::CFG_LAUNCH_REF:   ground_ref  = img[i][afve_pkg::ALT_W-1:0];
                afve_pkg::CFG_LAUNCH_DELTA: lift_margin = img[i][afve_pkg::DELTA_W-1:0];
                afve_pkg::CFG_DESCENT_VEL:  sink_rate   = img[i][afve_pkg::ALT_W-1:0];
                afve_pkg::CFG_LANDING_VEL:  rest_rate   = img[i][afve_pkg::DELTA_W-1:0];
                default: ;
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic offer_sample(input afve_pkg::t_alt raw, input afve_pkg::t_interval intv,
                                input logic descent, input bit typed,
                                input t_sample_result typed_res);
        t_sample_result forecast;
        in_ch.valid       <= 1'b1;
        in_ch.alt_sample  <= raw;
        in_ch.interval_ms <= intv;
        in_ch.in_descent  <= descent;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        forecast = advance_filter(raw, intv, descent);
        expected_results.push_back(typed ? typed_res : forecast);
        samples_in++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic emit(input longint alt, input afve_pkg::t_interval intv,
                        input logic descent);
        offer_sample(afve_pkg::t_alt'(sat_alt(alt)), intv, descent, 1'b0, '0);
        phase_budget--;
        pause_sender();
    endtask

    // pad, climb, apex, fall, touchdown with random rates and sensor jitter
    task automatic fly_once();
        longint      alt;
        longint      ground;
        int          n;
        int          k;
        int          s;
        t_flight_leg leg;
        ground = longint'(ground_ref);
        alt    = ground;
        for (s = LEG_PAD; s <= LEG_LANDED; s++) begin
            leg = t_flight_leg'(s);
            n = (leg == LEG_APEX) ? $urandom_range(1, 4) : $urandom_range(3, 16);
            for (k = 0; k < n && phase_budget > 0; k++) begin
                case (leg)
                    LEG_PAD, LEG_LANDED: alt = ground + longint'($urandom_range(0, 16)) - 8;
                    LEG_CLIMB:           alt = alt + longint'($urandom_range(50, 6000));
                    LEG_APEX:            alt = alt + longint'($urandom_range(0, 16)) - 8;
                    LEG_FALL: begin
                        alt = alt - longint'($urandom_range(20, 2500));
                        if (alt < ground)
                            alt = ground;
                    end
                    default: ;
                endcase
                emit(alt, pick_interval(), leg >= LEG_APEX);
            end
        end
    endtask

    task automatic flag_fault(input string what, input t_sample_result want,
                              input t_sample_result got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t %s: expected alt=%0d speed=%0d desc=%0b still=%0d",
                     $time, what, $signed(want.alt), $signed(want.speed), want.descending,
                     want.still);
            $display("    got alt=%0d speed=%0d desc=%0b still=%0d",
                     $signed(got.alt), $signed(got.speed), got.descending, got.still);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sample_result got;
        t_sample_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.alt        = out_ch.smoothed_altitude;
            got.speed      = out_ch.vertical_speed;
            got.descending = out_ch.is_descending;
            got.still      = out_ch.still_time_ms;
            results_seen++;
            if (expected_results.size() == 0) begin
                flag_fault("unexpected beat", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.alt !== want.alt || got.speed !== want.speed
                    || got.descending !== want.descending || got.still !== want.still)
                    flag_fault("mismatch", want, got);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off that backs up the block
    initial begin
        int stretch;
        int gap;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 30);
            out_ch.ready <= 1'b1;
            repeat (stretch) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || i_cfg_we === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("** altitude_filter_velocity_estimator: FAILED **");
        $finish;
    end

    initial begin
        int           r;
        int           ph;
        int           n;
        int           k;
        t_reg_setting setting;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= afve_pkg::CFG_PREV_WEIGHT;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.alt_sample  <= '0;
        in_ch.interval_ms <= '0;
        in_ch.in_descent  <= 1'b0;
        w_prev      = afve_pkg::RST_PREV_WEIGHT;
        w_raw       = afve_pkg::RST_RAW_WEIGHT;
        snap_eps    = afve_pkg::RST_ZERO_EPS;
        min_dt      = afve_pkg::RST_MIN_INTERVAL;
        ground_ref  = afve_pkg::RST_LAUNCH_REF;
        lift_margin = afve_pkg::RST_LAUNCH_DELTA;
        sink_rate   = afve_pkg::RST_DESCENT_VEL;
        rest_rate   = afve_pkg::RST_LANDING_VEL;
        est_alt     = '0;
        last_alt    = '0;
        rest_ms     = '0;
        samples_in    = 0;
        results_seen  = 0;
        fault_count   = 0;
        settings_done = 0;
        calm          = 1'b0;
        squeeze_req   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; the first group runs on the reset register values
        setting = SET_RESET;
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].setting != setting) begin
                setting = dir_rows[r].setting;
                settle();
                load_regs(setting);
            end
            offer_sample(dir_rows[r].raw, dir_rows[r].intv, dir_rows[r].descent,
                         dir_rows[r].typed, dir_rows[r].want);
            pause_sender();
        end

        // random flights and noise under a series of register settings
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            load_regs((ph == 0) ? SET_RESET : (ph == 1) ? SET_MIN :
                      (ph == 2) ? SET_MAX : SET_RANDOM);
            calm = (ph == SQUEEZE_PHASE) || ($urandom_range(0, 4) == 0);
            if (ph == SQUEEZE_PHASE)
                squeeze_req = 1'b1;
            phase_budget = ITEMS_PER_PHASE;
            while (phase_budget > 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n && phase_budget > 0; k++)
                        emit(($urandom_range(0, 4) == 0) ?
                             longint'($urandom_range(0, 64)) - 32 :
                             longint'(afve_pkg::t_alt'($urandom)),
                             afve_pkg::t_interval'($urandom), 1'($urandom));
                end else begin
                    fly_once();
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d altitude samples over %0d register loads", samples_in,
                 settings_done);
        $display("Checked %0d result beats, %0d mismatches, one %0d-cycle receiver hold-off",
                 results_seen, fault_count, HOLD_CYCLES);
        if (fault_count == 0 && expected_results.size() == 0)
            $display("** altitude_filter_velocity_estimator: PASSED **");
        else
            $display("** altitude_filter_velocity_estimator: FAILED **");
        $finish;
    end

endmodule
